>>> rtl/bld_pkg.sv
`default_nettype none
package bld_pkg;

  // sample width after masking, numerator and quotient widths
  localparam int SAMPLE_W = 10;
  localparam int NUM_W    = 19;
  localparam int VALUE_W  = 16;
  localparam int LEVEL_W  = 3;
  localparam int REPEAT_W = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // restoring divider runs one quotient bit per cycle
  localparam int DIV_STEPS = NUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // scale constants
  localparam logic [8:0]  SCALE_RATIO = 9'h181;
  localparam logic [8:0]  SCALE_MV    = 9'd372;
  localparam logic [9:0]  OFFSET_MV   = 10'd770;
  localparam logic [VALUE_W-1:0] VALUE_SAT = 16'hFFFF;

  // level codes
  localparam logic [LEVEL_W-1:0] LEVEL_NONE = 3'd7;
  localparam logic [LEVEL_W-1:0] LEVEL_SKIP = 3'd2;

  // threshold registers
  localparam int THR_REGS = 5;
  localparam logic [VALUE_W-1:0] THR_RESET [THR_REGS] = '{
    16'd355, 16'd381, 16'd393, 16'd408, 16'd412
  };
  localparam logic [2:0] THR_COUNT_RESET = 3'd5;
  localparam logic [REPEAT_W-1:0] SETTLE_RESET = 8'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THR_COUNT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR_FIRST   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THR_LAST    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE      = 3'd7;

  // divider request and response
  typedef struct packed {
    logic                start;
    logic [NUM_W-1:0]    dividend;
    logic [SAMPLE_W-1:0] divisor;
  } bld_div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quotient;
  } bld_div_rsp_t;

endpackage
`default_nettype wire

>>> rtl/bld_divider.sv
`default_nettype none
module bld_divider (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire bld_pkg::bld_div_req_t req,
  output bld_pkg::bld_div_rsp_t      rsp
);
  import bld_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SAMPLE_W-1:0]  rem_r, rem_nxt;
  logic [NUM_W-1:0]     quo_r, quo_nxt;
  logic [SAMPLE_W-1:0]  div_r, div_nxt;
  logic [SAMPLE_W:0]    rem_sh;
  logic [SAMPLE_W:0]    rem_diff;
  logic                 fits;

  // one restoring step: shift in the next dividend bit, try a subtract
  assign rem_sh   = {rem_r, quo_r[NUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, div_r};
  assign fits     = rem_sh >= {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      div_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? rem_diff[SAMPLE_W-1:0] : rem_sh[SAMPLE_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule
`default_nettype wire

>>> rtl/bld_debounce.sv
`default_nettype none
module bld_debounce #(
  parameter int NSLOT = 5
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          update,
  input  wire logic [bld_pkg::VALUE_W-1:0]   value,
  input  wire logic [bld_pkg::VALUE_W-1:0]   thr [NSLOT],
  input  wire logic [2:0]                    thr_count,
  input  wire logic [bld_pkg::REPEAT_W-1:0]  settle_repeats,
  output logic      [bld_pkg::LEVEL_W-1:0]   level_nxt,
  output logic                               known_nxt
);
  import bld_pkg::*;

  logic [LEVEL_W-1:0]  cand_r, cand_nxt;
  logic [REPEAT_W-1:0] rep_r, rep_nxt;
  logic [LEVEL_W-1:0]  lvl_r;
  logic                known_r;
  logic [2:0]          cnt_eff;
  logic [LEVEL_W-1:0]  raw_lvl;
  logic [LEVEL_W-1:0]  raw;
  logic [REPEAT_W-1:0] settle;
  logic [REPEAT_W:0]   rep_inc;

  // clamp count to the implemented slots
  assign cnt_eff = (thr_count > 3'(NSLOT)) ? 3'(NSLOT) : thr_count;

  // first threshold at or above the value
  always_comb begin
    logic found;
    found   = 1'b0;
    raw_lvl = cnt_eff;
    for (int i = 0; i < NSLOT; i++) begin
      if (!found && (3'(i) < cnt_eff) && (value <= thr[i])) begin
        raw_lvl = 3'(i);
        found   = 1'b1;
      end
    end
  end

  // levels above the skipped one move down
  assign raw     = (raw_lvl > LEVEL_SKIP) ? raw_lvl - 1'b1 : raw_lvl;
  assign settle  = (settle_repeats == '0) ? REPEAT_W'(1) : settle_repeats;
  assign rep_inc = {1'b0, rep_r} + 1'b1;

  // repeat counter and report
  always_comb begin
    cand_nxt  = cand_r;
    rep_nxt   = rep_r;
    level_nxt = lvl_r;
    known_nxt = known_r;
    if (raw != cand_r) begin
      cand_nxt = raw;
      rep_nxt  = '0;
    end else if (rep_inc == {1'b0, settle}) begin
      rep_nxt   = rep_inc[REPEAT_W-1:0];
      level_nxt = cand_r;
      known_nxt = 1'b1;
    end else if (rep_inc > {1'b0, settle}) begin
      rep_nxt = settle - 1'b1;
    end else begin
      rep_nxt = rep_inc[REPEAT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r  <= LEVEL_NONE;
      rep_r   <= '0;
      lvl_r   <= '0;
      known_r <= 1'b0;
    end else if (update) begin
      cand_r  <= cand_nxt;
      rep_r   <= rep_nxt;
      lvl_r   <= level_nxt;
      known_r <= known_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/battery_level_debounce.sv
`default_nettype none
// battery level monitor with debounce
//
// input channel: in_valid / in_stall carry one request of two converter
// samples, supply and reference. in_stall is high while a request is being
// worked on, so one request is in the block at a time.
// result channel: out_valid / out_stall carry one result per request:
// the debounced level, whether any level is known yet, and the measured
// supply value. the result sits in an output register; a new request is
// taken while it waits.
// the numerator is loaded into the bit-serial divider at acceptance; the
// divider retires one quotient bit per cycle for every numerator bit, then
// hands over the quotient, which is quantized and debounced into the output
// register. a new request is taken only once the last one has finished;
// the input reopens when the result is registered.
// a stalled receiver holds the result; a finished request then waits in
// the last step until the output register is free.
// config: cfg_wr_en writes cfg_wdata to register cfg_index; write only
// while idle. reset restores all registers to their defaults and clears
// the debounce state (no level known).
module battery_level_debounce #(
  parameter int ADC_BITS        = 10,
  parameter int THRESHOLD_SLOTS = 5
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [ADC_BITS-1:0]             in_supply_sample,
  input  wire logic [ADC_BITS-1:0]             in_reference_sample,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [bld_pkg::LEVEL_W-1:0]     out_stable_level,
  output logic                                 out_level_known,
  output logic      [bld_pkg::VALUE_W-1:0]     out_measured_value,
  input  wire logic                            cfg_wr_en,
  input  wire logic [bld_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bld_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import bld_pkg::*;

  localparam int EFF_BITS = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;
  localparam int NSLOT = (THRESHOLD_SLOTS < THR_REGS) ? THRESHOLD_SLOTS : THR_REGS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic                  mode_r;
  logic [2:0]            thr_count_r;
  logic [VALUE_W-1:0]    thr_r [NSLOT];
  logic [REPEAT_W-1:0]   settle_r;
  logic                  ref_zero_r;
  logic                  out_valid_r;
  logic [LEVEL_W-1:0]    out_level_r;
  logic                  out_known_r;
  logic [VALUE_W-1:0]    out_value_r;
  logic [SAMPLE_W-1:0]   sup;
  logic [SAMPLE_W-1:0]   refs;
  logic [NUM_W-1:0]      numer;
  logic                  accept;
  logic                  finish;
  logic [VALUE_W-1:0]    value;
  logic [LEVEL_W-1:0]    level_nxt;
  logic                  known_nxt;
  bld_div_req_t          div_req;
  bld_div_rsp_t          div_rsp;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      thr_count_r <= THR_COUNT_RESET;
      settle_r    <= SETTLE_RESET;
    end else if (cfg_wr_en) begin
      if (cfg_index == REG_SCALE_MODE) mode_r <= cfg_wdata[0];
      if (cfg_index == REG_THR_COUNT) thr_count_r <= cfg_wdata[2:0];
      if (cfg_index == REG_SETTLE) settle_r <= cfg_wdata[REPEAT_W-1:0];
    end
  end

  for (genvar g = 0; g < NSLOT; g++) begin : g_thr
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        thr_r[g] <= THR_RESET[g];
      end else if (cfg_wr_en && (cfg_index == REG_THR_FIRST + CFG_IDX_W'(g))) begin
        thr_r[g] <= cfg_wdata[VALUE_W-1:0];
      end
    end
  end

  // masked samples and scaled numerator
  assign sup  = SAMPLE_W'(in_supply_sample[EFF_BITS-1:0]);
  assign refs = SAMPLE_W'(in_reference_sample[EFF_BITS-1:0]);
  assign numer = mode_r ? (NUM_W'(sup) * NUM_W'(SCALE_MV) + NUM_W'(OFFSET_MV))
                        : (NUM_W'(sup) * NUM_W'(SCALE_RATIO));

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign finish   = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  assign div_req.start    = accept;
  assign div_req.dividend = numer;
  assign div_req.divisor  = refs;

  bld_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // saturate on zero reference or wide quotient
  assign value = (ref_zero_r || (div_rsp.quotient[NUM_W-1:VALUE_W] != '0))
                 ? VALUE_SAT : div_rsp.quotient[VALUE_W-1:0];

  bld_debounce #(.NSLOT(NSLOT)) u_deb (
    .clk            (clk),
    .rst_n          (rst_n),
    .update         (finish),
    .value          (value),
    .thr            (thr_r),
    .thr_count      (thr_count_r),
    .settle_repeats (settle_r),
    .level_nxt      (level_nxt),
    .known_nxt      (known_nxt)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept) state_nxt = S_DIV;
      S_DIV:  if (div_rsp.done) state_nxt = S_DONE;
      S_DONE: if (finish) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) ref_zero_r <= (refs == '0);
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_level_r <= '0;
      out_known_r <= 1'b0;
      out_value_r <= '0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
      out_level_r <= level_nxt;
      out_known_r <= known_nxt;
      out_value_r <= value;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_stable_level   = out_level_r;
  assign out_level_known    = out_known_r;
  assign out_measured_value = out_value_r;

endmodule
`default_nettype wire

>>> rtl/bld_checker.sv
`default_nettype none
module bld_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_stall,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic [bld_pkg::LEVEL_W-1:0]  out_stable_level,
  input wire logic                         out_level_known,
  input wire logic [bld_pkg::VALUE_W-1:0]  out_measured_value
);
  import bld_pkg::*;

  // a request keeps the input side busy while it is divided
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall ##1 in_stall)
    else $error("input taken again right after a request");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_measured_value))
    else $error("stalled result changed");

  // once a level is known it stays known
  a_known_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_level_known |=> out_level_known)
    else $error("level known dropped");

  // no level is shown before one is known
  a_level_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_level_known |-> out_stable_level == '0)
    else $error("level shown while none known");

endmodule

bind battery_level_debounce bld_checker u_bld_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_stable_level   (out_stable_level),
  .out_level_known    (out_level_known),
  .out_measured_value (out_measured_value)
);
`default_nettype wire
